>>> hw/rtl/edd_pkg.sv
// Package for the error diffusion dither block: widths, reset values, codes
// and the structs passed between its modules. No dependencies.
package edd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int LEVEL_W    = 8;
    localparam int THR_W      = 8;
    localparam int LWIDTH_W   = 12;
    localparam int ERR_W      = 14;
    localparam int WORK_W     = 12;
    localparam int SUM_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int CMP_W      = (LWIDTH_W > COL_W + 1) ? LWIDTH_W : COL_W + 1;

    // 255.0 in unsigned 8.4
    localparam logic [WORK_W-1:0] FULL_SCALE = WORK_W'(4080);

    localparam logic [THR_W-1:0]    THRESHOLD_RST  = THR_W'(100);
    localparam logic [LWIDTH_W-1:0] LINE_WIDTH_RST = LWIDTH_W'(640);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_KERNEL    = 2'd1,
        CFG_WIDTH     = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        KERNEL_FS = 1'b0,
        KERNEL_SL = 1'b1
    } t_kernel;

    typedef struct packed {
        logic [THR_W-1:0]    threshold;
        t_kernel             kernel;
        logic [LWIDTH_W-1:0] line_width;
    } t_cfg;

    // Pixel as it leaves the scan stage, with its position resolved
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               frame_start;
        logic               first_row;
        logic               at_left;
        logic               at_right;
        logic [COL_W-1:0]   col;
    } t_scan_item;

    typedef struct packed {
        logic                    valid;
        logic [COL_W-1:0]        addr;
        logic signed [ERR_W-1:0] data;
    } t_wr_req;

endpackage

>>> hw/rtl/edd_if.sv
// Handshake interfaces of the error diffusion dither block: pixel input,
// dithered bit output and configuration writes. Depends on edd_pkg.
interface edd_pix_if;
    import edd_pkg::*;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] pixel_level;
    logic               frame_start;

    modport source (output valid, pixel_level, frame_start, input ready);
    modport sink   (input valid, pixel_level, frame_start, output ready);
endinterface

interface edd_dith_if;
    logic valid;
    logic ready;
    logic is_white;

    modport source (output valid, is_white, input ready);
    modport sink   (input valid, is_white, output ready);
endinterface

interface edd_cfg_if;
    import edd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, addr, wdata, input ready);
    modport sink   (input valid, addr, wdata, output ready);
endinterface

>>> hw/rtl/edd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read returns the contents before a same-cycle write. No dependencies.
module edd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/edd_cfg.sv
// Configuration register file of the dither block: threshold, kernel select
// and line width. Depends on edd_pkg and edd_if.
module edd_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    edd_cfg_if.sink        i_cfg,
    output edd_pkg::t_cfg  o_cfg
);
    import edd_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold  <= THRESHOLD_RST;
            r_cfg.kernel     <= KERNEL_FS;
            r_cfg.line_width <= LINE_WIDTH_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.addr))
                CFG_THRESHOLD: r_cfg.threshold  <= i_cfg.wdata[THR_W-1:0];
                CFG_KERNEL:    r_cfg.kernel     <= t_kernel'(i_cfg.wdata[0]);
                CFG_WIDTH:     r_cfg.line_width <= i_cfg.wdata[LWIDTH_W-1:0];
                default: ;  // unmapped index: drop
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/edd_scan.sv
// Input stage of the dither block: raster position tracking, line store read
// address and the input register. Depends on edd_pkg and edd_if.
module edd_scan (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    edd_pix_if.sink                  i_pix,
    input  logic [edd_pkg::LWIDTH_W-1:0] i_line_width,
    input  logic                     i_advance,
    output edd_pkg::t_scan_item      o_item,
    output logic                     o_item_valid,
    output logic [edd_pkg::COL_W-1:0] o_rd_addr
);
    import edd_pkg::*;

    logic [COL_W-1:0] r_col;
    logic             r_first;
    t_scan_item       r_item;
    logic             r_item_valid;

    logic [CMP_W-1:0] eff_width;
    logic [COL_W-1:0] cur_x;
    logic             cur_left;
    logic             cur_right;
    logic             cur_first;
    logic             accept;

    // Width 0 acts as 1, anything past the line store acts as its depth
    always_comb begin
        if (i_line_width == '0) begin
            eff_width = CMP_W'(1);
        end else if (CMP_W'(i_line_width) > CMP_W'(MAX_WIDTH)) begin
            eff_width = CMP_W'(MAX_WIDTH);
        end else begin
            eff_width = CMP_W'(i_line_width);
        end
    end

    assign cur_x     = i_pix.frame_start ? '0 : r_col;
    assign cur_left  = (cur_x == '0);
    assign cur_right = (CMP_W'(cur_x) + CMP_W'(1)) >= eff_width;
    assign cur_first = i_pix.frame_start | r_first;

    assign i_pix.ready = !r_item_valid | i_advance;
    assign accept      = i_pix.valid & i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_first      <= 1'b1;
            r_item_valid <= 1'b0;
        end else if (accept) begin
            r_col        <= cur_right ? '0 : COL_W'(cur_x + 1'b1);
            r_first      <= cur_right ? 1'b0 : cur_first;
            r_item_valid <= 1'b1;
        end else if (i_advance) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.level       <= i_pix.pixel_level;
            r_item.frame_start <= i_pix.frame_start;
            r_item.first_row   <= cur_first;
            r_item.at_left     <= cur_left;
            r_item.at_right    <= cur_right;
            r_item.col         <= cur_x;
        end
    end

    // Re-read the held pixel's entry while stalled, else fetch the new one
    assign o_rd_addr    = (r_item_valid && !i_advance) ? r_item.col : cur_x;
    assign o_item       = r_item;
    assign o_item_valid = r_item_valid;

endmodule

>>> hw/rtl/edd_quant.sv
// Quantize-and-diffuse stage of the dither block: working value, threshold,
// error spread, line store write-back and the output register.
// Depends on edd_pkg and edd_if.
module edd_quant (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  edd_pkg::t_cfg                 i_cfg,
    input  edd_pkg::t_scan_item           i_item,
    input  logic                          i_item_valid,
    input  logic [edd_pkg::ERR_W-1:0]     i_rd_data,
    output logic                          o_advance,
    output edd_pkg::t_wr_req              o_wr,
    edd_dith_if.source                    o_dith
);
    import edd_pkg::*;

    // (e * num) >> sh with truncation toward zero
    function automatic logic signed [ERR_W-1:0] spread(
        input logic signed [ERR_W-1:0] e,
        input logic [2:0]              num,
        input logic [2:0]              sh
    );
        logic [ERR_W-1:0] mag;
        logic [14:0]      prod;
        logic [ERR_W-1:0] part;
        mag  = e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
        prod = 15'(mag[WORK_W-1:0]) * 15'(num);
        part = ERR_W'(prod >> sh);
        return e[ERR_W-1] ? -$signed(part) : $signed(part);
    endfunction

    logic signed [ERR_W-1:0] r_rc;
    logic signed [ERR_W-1:0] r_bp0;
    logic signed [ERR_W-1:0] r_bp1;
    t_wr_req                 r_ovl;   // row-end entry not yet in the RAM
    t_wr_req                 r_prev;  // RAM write of the previous cycle
    logic                    r_out_valid;
    logic                    r_out_white;

    logic                    commit;
    logic signed [ERR_W-1:0] rc, bp0, bp1, store_val, ram_val;
    logic signed [SUM_W-1:0] w_sum;
    logic [WORK_W-1:0]       w_clamp;
    logic                    white;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] e_right, e_bl, e_b, e_br;
    logic signed [ERR_W-1:0] nbp0, nbp1;
    t_wr_req                 left_wr;
    t_wr_req                 wr;

    assign o_advance = !r_out_valid | o_dith.ready;
    assign commit    = i_item_valid & o_advance;

    assign rc  = i_item.frame_start ? '0 : r_rc;
    assign bp0 = i_item.frame_start ? '0 : r_bp0;
    assign bp1 = i_item.frame_start ? '0 : r_bp1;

    // Newest copy of the entry wins: row-end hold, then last write, then RAM
    always_comb begin
        if (r_ovl.valid && r_ovl.addr == i_item.col) begin
            ram_val = r_ovl.data;
        end else if (r_prev.valid && r_prev.addr == i_item.col) begin
            ram_val = r_prev.data;
        end else begin
            ram_val = $signed(i_rd_data);
        end
    end
    assign store_val = i_item.first_row ? '0 : ram_val;

    always_comb begin
        w_sum = $signed({{(SUM_W-LEVEL_W-4){1'b0}}, i_item.level, 4'b0000})
              + SUM_W'(rc) + SUM_W'(store_val);
        if (w_sum < 0) begin
            w_clamp = '0;
        end else if (w_sum > $signed(SUM_W'(FULL_SCALE))) begin
            w_clamp = FULL_SCALE;
        end else begin
            w_clamp = w_sum[WORK_W-1:0];
        end
    end

    assign white = w_clamp > {i_cfg.threshold, 4'b0000};
    assign err   = white ? $signed(ERR_W'(w_clamp)) - $signed(ERR_W'(FULL_SCALE))
                         : $signed(ERR_W'(w_clamp));

    always_comb begin
        case (i_cfg.kernel)
            KERNEL_SL: begin
                e_right = spread(err, 3'd2, 3'd2);
                e_bl    = spread(err, 3'd1, 3'd2);
                e_b     = spread(err, 3'd1, 3'd2);
                e_br    = '0;
            end
            default: begin
                e_right = spread(err, 3'd7, 3'd4);
                e_bl    = spread(err, 3'd3, 3'd4);
                e_b     = spread(err, 3'd5, 3'd4);
                e_br    = spread(err, 3'd1, 3'd4);
            end
        endcase
        // Drop spreads that leave the row
        if (i_item.at_left) begin
            e_bl = '0;
        end
        if (i_item.at_right) begin
            e_right = '0;
            e_br    = '0;
        end
    end

    assign nbp0 = bp0 + e_bl;
    assign nbp1 = bp1 + e_b;

    assign left_wr.valid = commit & !i_item.at_left;
    assign left_wr.addr  = COL_W'(i_item.col - 1'b1);
    assign left_wr.data  = nbp0;

    // Left write owns the port; otherwise flush the held row-end entry
    always_comb begin
        if (left_wr.valid) begin
            wr = left_wr;
        end else begin
            wr = r_ovl;
        end
    end
    assign o_wr = wr;

    always_ff @(posedge i_clk) begin
        r_prev.addr <= wr.addr;
        r_prev.data <= wr.data;
        if (commit && i_item.at_right) begin
            r_ovl.addr <= i_item.col;
            r_ovl.data <= nbp1;
        end
        if (!i_rst_n) begin
            r_rc        <= '0;
            r_bp0       <= '0;
            r_bp1       <= '0;
            r_ovl.valid <= 1'b0;
            r_prev.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_prev.valid <= wr.valid;
            if (commit && i_item.at_right) begin
                r_ovl.valid <= 1'b1;
            end else if (!left_wr.valid) begin
                r_ovl.valid <= 1'b0;
            end
            if (commit) begin
                if (i_item.at_right) begin
                    r_rc  <= '0;
                    r_bp0 <= '0;
                    r_bp1 <= '0;
                end else begin
                    r_rc  <= e_right;
                    r_bp0 <= nbp1;
                    r_bp1 <= e_br;
                end
                r_out_valid <= 1'b1;
            end else if (o_dith.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_white <= white;
        end
    end

    assign o_dith.valid    = r_out_valid;
    assign o_dith.is_white = r_out_white;

endmodule

>>> hw/rtl/error_diffusion_dither.sv
// Top level of the error diffusion dither block: config registers, scan
// stage, line store RAM and quantize stage. Depends on edd_pkg, edd_if,
// edd_cfg, edd_scan, edd_ram and edd_quant.
//
//  port    | dir | payload                        | request accepted when
//  --------+-----+--------------------------------+-----------------------
//  i_pix   | in  | pixel_level[7:0], frame_start  | valid & ready
//  o_dith  | out | is_white                       | valid & ready
//  i_cfg   | in  | addr[1:0], wdata[11:0]         | valid & ready (ready=1)
//
// One pixel per clock sustained while o_dith is ready; a pixel's bit passes
// through the input register, then the quantize stage into the output
// register. The line store is a 2048 x 14 RAM with one write and one
// registered read port; the read is issued as the pixel request is taken.
// Reset is synchronous; no clearing pass runs, the line store is only read
// after the first row of a frame has filled it.
// When o_dith stalls, the output register and the input register hold and
// the line store entry of the held pixel is fetched again each cycle.
module error_diffusion_dither (
    input  logic        i_clk,
    input  logic        i_rst_n,
    edd_pix_if.sink     i_pix,
    edd_dith_if.source  o_dith,
    edd_cfg_if.sink     i_cfg
);
    import edd_pkg::*;

    t_cfg             cfg;
    t_scan_item       item;
    logic             item_valid;
    logic             advance;
    logic [COL_W-1:0] rd_addr;
    logic [ERR_W-1:0] rd_data;
    t_wr_req          wr;

    // Register writes
    edd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Track row and column, take the pixel request, issue the store read
    edd_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_line_width (cfg.line_width),
        .i_advance    (advance),
        .o_item       (item),
        .o_item_valid (item_valid),
        .o_rd_addr    (rd_addr)
    );

    // Next-row errors, one entry per column
    edd_ram #(
        .WIDTH (ERR_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr.valid),
        .i_wr_addr (wr.addr),
        .i_wr_data (wr.data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Threshold, diffuse the error, write back, present the bit
    edd_quant u_quant (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item       (item),
        .i_item_valid (item_valid),
        .i_rd_data    (rd_data),
        .o_advance    (advance),
        .o_wr         (wr),
        .o_dith       (o_dith)
    );

endmodule

>>> hw/rtl/edd_checker.sv
// Port-level checks for the error diffusion dither block and the bind that
// attaches them to the top level. Depends on error_diffusion_dither.
module edd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_pix_valid,
    input logic i_pix_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_white
);

    // A stalled bit holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_white))
        else $error("dither bit changed while stalled");

    // A bit only appears as the result of an accepted pixel request
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_pix_valid && i_pix_ready, 2))
        else $error("dither bit without a pixel request");

    // With the output free the input must be open
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_pix_ready)
        else $error("pixel input blocked with empty output");

    // No stall downstream: the bit follows the request through the input and output registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && i_pix_ready) ##1 i_out_ready |=> i_out_valid)
        else $error("dither bit late");

endmodule

bind error_diffusion_dither edd_checker u_edd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_valid (i_pix.valid),
    .i_pix_ready (i_pix.ready),
    .i_out_valid (o_dith.valid),
    .i_out_ready (o_dith.ready),
    .i_out_white (o_dith.is_white)
);
